// ===== rtl/cwsm_pkg.sv =====
package cwsm_pkg;

  localparam int NUM_SLOTS = 9;
  localparam int SLOT_W = 4;
  localparam int CS_W = 23;
  localparam int HOLD_W = 16;

  localparam logic [1:0] CFG_X_ORIGIN = 2'd0;
  localparam logic [1:0] CFG_Y_ORIGIN = 2'd1;
  localparam logic [1:0] CFG_CHUNK_SIZE = 2'd2;
  localparam logic [1:0] CFG_HOLD_TICKS = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_HOLD,
    ST_STATUS,
    ST_EVICT,
    ST_PLACE,
    ST_REPORT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_pos;
    logic div_start;
    logic hold_eval;
    logic evict_step;
    logic place_step;
    logic report_step;
    logic commit;
    logic out_status;
    logic out_slot;
  } cmd_t;

  typedef struct packed {
    logic col_done;
    logic div_done;
    logic update;
    logic scan_last;
    logic out_busy;
  } status_t;

endpackage

// ===== rtl/chunk_window_slot_manager_core.sv =====
// An accepted position yields a status result, or on an update an evict pass over
// the 9 slots and a place pass over the window, then a report of every slot.
// A new position is taken only in idle, once its last result has been issued, so
// output stalls hold the flow too. The shared bit-serial divider, run once for
// column and once for row, takes most of the time per position.
// Reset (rst_n low, synchronous): configuration registers to defaults, slots free, chunk -1.
module chunk_window_slot_manager_core #(
  parameter int WINDOW_RADIUS = 1,
  parameter int INDEX_WIDTH = 12,
  parameter int POS_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [POS_WIDTH-1:0]   in_pos_x,
  input  logic signed [POS_WIDTH-1:0]   in_pos_y,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [31:0]                   cfg_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_kind,
  output logic                          out_pending,
  output logic [15:0]                   out_countdown,
  output logic [3:0]                    out_slot,
  output logic signed [INDEX_WIDTH-1:0] out_chunk_row,
  output logic signed [INDEX_WIDTH-1:0] out_chunk_col,
  output logic                          out_occupied,
  output logic                          out_newly_loaded,
  output logic                          out_evicted,
  output logic                          out_last
);
  import cwsm_pkg::*;

  cmd_t cmd;
  status_t sts;

  assign cfg_ready = 1'b1;

  cwsm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .sts(sts), .cmd(cmd)
  );

  cwsm_datapath #(
    .WINDOW_RADIUS(WINDOW_RADIUS), .INDEX_WIDTH(INDEX_WIDTH), .POS_WIDTH(POS_WIDTH)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .pos_x(in_pos_x), .pos_y(in_pos_y),
    .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_val(cfg_data),
    .out_stall(out_stall), .out_valid(out_valid), .out_kind(out_kind),
    .out_pending(out_pending), .out_countdown(out_countdown), .out_slot(out_slot),
    .out_chunk_row(out_chunk_row), .out_chunk_col(out_chunk_col),
    .out_occupied(out_occupied), .out_newly_loaded(out_newly_loaded),
    .out_evicted(out_evicted), .out_last(out_last)
  );
endmodule

// ===== rtl/cwsm_div.sv =====
module cwsm_div #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 23
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic        [DEN_W-1:0] den,
  output logic                    done,
  output logic signed [NUM_W-1:0] quot
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic neg_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic busy_r, done_r;
  logic [DEN_W:0] trial;
  logic [NUM_W-1:0] mag;

  always_comb begin
    mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    trial = {rem_r[DEN_W-1:0], q_r[NUM_W-1]};
    rem_nxt = trial;
    q_nxt = {q_r[NUM_W-2:0], 1'b0};
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = trial - {1'b0, den_r};
      q_nxt[0] = 1'b1;
    end
    cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_nxt;
        if (cnt_nxt == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      q_r <= mag;
      rem_r <= '0;
      den_r <= (den == '0) ? DEN_W'(1) : den;
      neg_r <= num[NUM_W-1];
    end else if (busy_r) begin
      q_r <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = neg_r ? NUM_W'(-q_r) : NUM_W'(q_r);
endmodule

// ===== rtl/cwsm_datapath.sv =====
module cwsm_datapath #(
  parameter int WINDOW_RADIUS = 1,
  parameter int INDEX_WIDTH = 12,
  parameter int POS_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cwsm_pkg::cmd_t                cmd,
  output cwsm_pkg::status_t             sts,
  input  logic signed [POS_WIDTH-1:0]   pos_x,
  input  logic signed [POS_WIDTH-1:0]   pos_y,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_idx,
  input  logic [31:0]                   cfg_val,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic                          out_kind,
  output logic                          out_pending,
  output logic [15:0]                   out_countdown,
  output logic [3:0]                    out_slot,
  output logic signed [INDEX_WIDTH-1:0] out_chunk_row,
  output logic signed [INDEX_WIDTH-1:0] out_chunk_col,
  output logic                          out_occupied,
  output logic                          out_newly_loaded,
  output logic                          out_evicted,
  output logic                          out_last
);
  import cwsm_pkg::*;

  localparam int NUM_W = POS_WIDTH + 2;
  localparam int SIDE = 2 * WINDOW_RADIUS + 1;
  localparam int WIN = SIDE * SIDE;
  localparam int WIN_W = $clog2(WIN + 1);
  localparam int SIDE_W = $clog2(SIDE + 1);
  localparam logic signed [NUM_W-1:0] IMAX = NUM_W'((1 << (INDEX_WIDTH - 1)) - 1);
  localparam logic signed [NUM_W-1:0] IMIN = -NUM_W'(1 << (INDEX_WIDTH - 1));

  logic signed [POS_WIDTH-1:0] x_origin_r, y_origin_r;
  logic [CS_W-1:0] chunk_size_r;
  logic [HOLD_W-1:0] hold_ticks_r;
  logic signed [POS_WIDTH-1:0] px_r, py_r;
  logic signed [INDEX_WIDTH-1:0] row_r, col_r, cur_row_r, cur_col_r;
  logic hold_active_r, update_r;
  logic [HOLD_W-1:0] hold_count_r;
  logic [HOLD_W-1:0] cnt_nxt;
  logic act_nxt, upd_nxt;

  logic signed [INDEX_WIDTH-1:0] slot_row_r [NUM_SLOTS];
  logic signed [INDEX_WIDTH-1:0] slot_col_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] used_r, nl_r, ev_r;

  logic [SLOT_W-1:0] sidx_r;
  logic [WIN_W-1:0] widx_r;
  logic [SIDE_W-1:0] wi_r, wj_r;

  logic signed [NUM_W-1:0] num_x, num_y, qsel;
  logic signed [NUM_W-1:0] num;
  logic div_done;
  logic div_phase_r;
  logic signed [INDEX_WIDTH-1:0] sat_q;

  logic signed [INDEX_WIDTH-1:0] win_row [WIN];
  logic signed [INDEX_WIDTH-1:0] win_col [WIN];
  logic signed [INDEX_WIDTH-1:0] wr_cur, wc_cur;
  logic keep;
  logic [NUM_SLOTS-1:0] found_v, free_v;
  logic [SLOT_W-1:0] free_idx;
  logic free_any;

  logic ov_r, okind_r, opend_r, oocc_r, onl_r, oev_r, olast_r;
  logic [15:0] ocd_r;
  logic [3:0] oslot_r;
  logic signed [INDEX_WIDTH-1:0] orow_r, ocol_r;

  assign num_x = NUM_W'(px_r) - NUM_W'(x_origin_r);
  assign num_y = NUM_W'(y_origin_r) - NUM_W'(py_r) + NUM_W'({1'b0, chunk_size_r == '0 ?
                 CS_W'(1) : chunk_size_r});
  assign num = div_phase_r ? num_y : num_x;

  cwsm_div #(.NUM_W(NUM_W), .DEN_W(CS_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(num),
    .den(chunk_size_r), .done(div_done), .quot(qsel)
  );

  always_comb begin
    if (qsel > IMAX) sat_q = INDEX_WIDTH'(IMAX);
    else if (qsel < IMIN) sat_q = INDEX_WIDTH'(IMIN);
    else sat_q = INDEX_WIDTH'(qsel);
  end

  always_comb begin
    for (int i = 0; i < SIDE; i++) begin
      for (int j = 0; j < SIDE; j++) begin
        win_row[i*SIDE+j] = INDEX_WIDTH'(row_r + INDEX_WIDTH'(i - WINDOW_RADIUS));
        win_col[i*SIDE+j] = INDEX_WIDTH'(col_r + INDEX_WIDTH'(j - WINDOW_RADIUS));
      end
    end
    wr_cur = INDEX_WIDTH'(row_r + INDEX_WIDTH'(int'(wi_r) - WINDOW_RADIUS));
    wc_cur = INDEX_WIDTH'(col_r + INDEX_WIDTH'(int'(wj_r) - WINDOW_RADIUS));
    keep = 1'b0;
    for (int k = 0; k < WIN; k++) begin
      if (win_row[k] == slot_row_r[sidx_r] && win_col[k] == slot_col_r[sidx_r]) keep = 1'b1;
    end
    for (int s = 0; s < NUM_SLOTS; s++) begin
      found_v[s] = used_r[s] && slot_row_r[s] == wr_cur && slot_col_r[s] == wc_cur;
      free_v[s] = !used_r[s];
    end
    free_idx = '0;
    free_any = 1'b0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (free_v[s]) begin
        free_idx = SLOT_W'(s);
        free_any = 1'b1;
      end
    end
  end

  always_comb begin
    act_nxt = hold_active_r;
    cnt_nxt = hold_count_r;
    upd_nxt = 1'b0;
    if (row_r == cur_row_r && col_r == cur_col_r) begin
      act_nxt = 1'b0;
      cnt_nxt = '0;
    end else begin
      if (hold_active_r) cnt_nxt = hold_count_r + HOLD_W'(1);
      else begin
        act_nxt = 1'b1;
        cnt_nxt = '0;
      end
      if (cnt_nxt == hold_ticks_r) begin
        upd_nxt = 1'b1;
        act_nxt = 1'b0;
        cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_origin_r <= '0;
      y_origin_r <= '0;
      chunk_size_r <= CS_W'(8192);
      hold_ticks_r <= '0;
      cur_row_r <= '1;
      cur_col_r <= '1;
      hold_active_r <= 1'b0;
      hold_count_r <= '0;
      used_r <= '0;
      update_r <= 1'b0;
      div_phase_r <= 1'b0;
      ov_r <= 1'b0;
      sidx_r <= '0;
      wi_r <= '0;
      wj_r <= '0;
      widx_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_X_ORIGIN: x_origin_r <= POS_WIDTH'(cfg_val);
          CFG_Y_ORIGIN: y_origin_r <= POS_WIDTH'(cfg_val);
          CFG_CHUNK_SIZE: chunk_size_r <= CS_W'(cfg_val);
          CFG_HOLD_TICKS: hold_ticks_r <= HOLD_W'(cfg_val);
          default: ;
        endcase
      end
      if (cmd.load_pos) div_phase_r <= 1'b0;
      if (div_done) begin
        if (!div_phase_r) begin
          col_r <= sat_q;
          div_phase_r <= 1'b1;
        end else row_r <= sat_q;
      end
      if (cmd.hold_eval) begin
        hold_active_r <= act_nxt;
        hold_count_r <= cnt_nxt;
        update_r <= upd_nxt;
        sidx_r <= '0;
        wi_r <= '0;
        wj_r <= '0;
        widx_r <= '0;
        nl_r <= '0;
        ev_r <= '0;
      end
      if (cmd.evict_step) begin
        if (used_r[sidx_r] && !keep) begin
          used_r[sidx_r] <= 1'b0;
          ev_r[sidx_r] <= 1'b1;
        end
        sidx_r <= (sidx_r == SLOT_W'(NUM_SLOTS - 1)) ? '0 : sidx_r + SLOT_W'(1);
      end
      if (cmd.place_step) begin
        if (found_v == '0 && free_any) begin
          used_r[free_idx] <= 1'b1;
          slot_row_r[free_idx] <= wr_cur;
          slot_col_r[free_idx] <= wc_cur;
          nl_r[free_idx] <= 1'b1;
        end
        widx_r <= widx_r + WIN_W'(1);
        if (wj_r == SIDE_W'(SIDE - 1)) begin
          wj_r <= '0;
          wi_r <= wi_r + SIDE_W'(1);
        end else wj_r <= wj_r + SIDE_W'(1);
      end
      if (cmd.commit) begin
        cur_row_r <= row_r;
        cur_col_r <= col_r;
      end
      ov_r <= cmd.out_status || cmd.out_slot || (ov_r && out_stall);
      if (cmd.out_status) begin
        okind_r <= 1'b0;
        opend_r <= hold_active_r;
        ocd_r <= hold_active_r ? hold_ticks_r - hold_count_r : '0;
        oslot_r <= '0;
        orow_r <= '0;
        ocol_r <= '0;
        oocc_r <= 1'b0;
        onl_r <= 1'b0;
        oev_r <= 1'b0;
        olast_r <= 1'b1;
      end
      if (cmd.out_slot) begin
        okind_r <= 1'b1;
        opend_r <= 1'b0;
        ocd_r <= '0;
        oslot_r <= sidx_r;
        orow_r <= used_r[sidx_r] ? slot_row_r[sidx_r] : '0;
        ocol_r <= used_r[sidx_r] ? slot_col_r[sidx_r] : '0;
        oocc_r <= used_r[sidx_r];
        onl_r <= nl_r[sidx_r];
        oev_r <= ev_r[sidx_r];
        olast_r <= sidx_r == SLOT_W'(NUM_SLOTS - 1);
        sidx_r <= sidx_r + SLOT_W'(1);
      end
    end
    if (cmd.load_pos) begin
      px_r <= pos_x;
      py_r <= pos_y;
    end
  end

  assign sts.col_done = div_done && !div_phase_r;
  assign sts.div_done = div_done && div_phase_r;
  assign sts.update = update_r;
  assign sts.scan_last = cmd.place_step ? (widx_r == WIN_W'(WIN - 1))
                                        : (sidx_r == SLOT_W'(NUM_SLOTS - 1));
  assign sts.out_busy = ov_r && out_stall;

  assign out_valid = ov_r;
  assign out_kind = okind_r;
  assign out_pending = opend_r;
  assign out_countdown = ocd_r;
  assign out_slot = oslot_r;
  assign out_chunk_row = orow_r;
  assign out_chunk_col = ocol_r;
  assign out_occupied = oocc_r;
  assign out_newly_loaded = onl_r;
  assign out_evicted = oev_r;
  assign out_last = olast_r;

`ifndef SYNTHESIS
  a_status_free: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !okind_r |-> olast_r) else $error("status not last");
  a_slot_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && okind_r |-> !opend_r && ocd_r == '0) else $error("slot report pending");
  a_nl_used: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_slot |=> (!out_newly_loaded || out_occupied)) else $error("loaded not occupied");
`endif
endmodule

// ===== rtl/cwsm_ctrl.sv =====
module cwsm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cwsm_pkg::status_t  sts,
  output cwsm_pkg::cmd_t     cmd
);
  import cwsm_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_DIV_START;
      ST_DIV_START: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (sts.div_done) state_nxt = ST_HOLD;
        else if (sts.col_done) state_nxt = ST_DIV_START;
      end
      ST_HOLD: state_nxt = ST_DONE;
      ST_DONE: state_nxt = sts.update ? ST_EVICT : ST_STATUS;
      ST_STATUS: if (!sts.out_busy) state_nxt = ST_IDLE;
      ST_EVICT: if (sts.scan_last) state_nxt = ST_PLACE;
      ST_PLACE: if (sts.scan_last) state_nxt = ST_REPORT;
      ST_REPORT: if (!sts.out_busy && sts.scan_last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = state_r != ST_IDLE;
    unique case (state_r)
      ST_IDLE: cmd.load_pos = in_valid;
      ST_DIV_START: cmd.div_start = 1'b1;
      ST_DIV_WAIT: ;
      ST_HOLD: cmd.hold_eval = 1'b1;
      ST_DONE: ;
      ST_STATUS: cmd.out_status = !sts.out_busy;
      ST_EVICT: cmd.evict_step = 1'b1;
      ST_PLACE: cmd.place_step = 1'b1;
      ST_REPORT: begin
        cmd.out_slot = !sts.out_busy;
        cmd.commit = !sts.out_busy && sts.scan_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

`ifndef SYNTHESIS
  a_one_out: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.out_status && cmd.out_slot)) else $error("two outputs");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> state_r == ST_IDLE) else $error("accept busy");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_pos |=> cmd.div_start) else $error("no divide");
`endif
endmodule
